>>> rtl/core/hsv2rgb_pkg.sv
// Shared types for the HSV to RGB pixel converter.
// Holds the hue sector code; no dependencies.
package hsv2rgb_pkg;

  // Hue sector, 60 degrees each, named by the hues at its two ends
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } sector_t;

endpackage

>>> rtl/core/hsv_to_rgb_converter_core.sv
// HSV to RGB pixel converter, eight-stage pipeline with valid/stall channels.
// Depends on hsv2rgb_pkg for the hue sector type.
//
// Usage:
//   Input channel in_*: one HSV pixel per word. in_hue is in units of
//   1/2^HUE_FRAC_BITS degree; a hue at or above 360 degrees is clamped to the
//   last legal step. in_saturation and in_brightness are unsigned fixed point,
//   all ones meaning 1.0. A word moves when valid is high and stall is low.
//   Output channel out_*: one RGB pixel per accepted word, in order, truncated.
//   Saturation at or below about 0.0001 of full scale gives grey (all = value).
//   Pipeline steps, in order: sector split, fraction divide, then two rounds
//   of multiply and divide by full scale, each split over a multiply and a
//   divide stage.
//   Throughput: one pixel per cycle, limited by nothing but out_stall.
//   Each stage loads whenever it is empty or the stage after it moves, so
//   bubbles close up; in_stall rises only when all eight stages hold a word
//   and out_stall is high. A stalled output word holds its value.
//   Reset (rst_n low, synchronous) empties the pipeline; no word is in flight.
module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned CHANNEL_BITS  = 16,
  parameter int unsigned HUE_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [HUE_FRAC_BITS+8:0]      in_hue,
  input  logic [CHANNEL_BITS-1:0]       in_saturation,
  input  logic [CHANNEL_BITS-1:0]       in_brightness,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CHANNEL_BITS-1:0]       out_red,
  output logic [CHANNEL_BITS-1:0]       out_green,
  output logic [CHANNEL_BITS-1:0]       out_blue
);

  localparam int unsigned CB         = CHANNEL_BITS;
  localparam int unsigned HF         = HUE_FRAC_BITS;
  localparam int unsigned HUE_W      = HF + 9;
  localparam int unsigned REM_W      = HF + 6;
  localparam int unsigned Y_W        = CB + 4;
  localparam int unsigned NSTG       = 8;
  localparam int unsigned RECIP_DIV  = 15;

  localparam logic [CB-1:0]    MAXV     = {CB{1'b1}};
  localparam logic [CB-1:0]    GREY_LIM = CB'(((64'd1 << CB) - 64'd1) / 64'd10000);
  localparam logic [HUE_W-1:0] SPAN     = HUE_W'(64'd60 << HF);
  localparam logic [HUE_W-1:0] HUE_LIM  = HUE_W'(64'd360 << HF);
  localparam logic [CB:0]      RECIP    = (CB+1)'((64'd1 << Y_W) / 64'd15);

  // floor(x / MAXV) for any product of two channel values
  function automatic logic [CB-1:0] div_maxv(input logic [2*CB-1:0] x);
    logic [2*CB:0] acc;
    acc = {1'b0, x} + {(CB+1)'(0), x[2*CB-1:CB]} + (2*CB+1)'(1);
    return acc[2*CB-1:CB];
  endfunction

  // ---------------------------------------------------------------- control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = !out_stall;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign vld_nxt   = {vld_r[NSTG-2:0], in_valid};
  assign in_stall  = !en[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  // stage 1: clamp hue, find sector and remainder
  logic [HUE_W-1:0] s1_hue_c;
  logic [8:0]       s1_deg;
  logic [HUE_W-1:0] s1_base;
  sector_t          s1_sec_nxt;
  logic [REM_W-1:0] s1_rem_nxt;
  sector_t          s1_sec_r;
  logic [REM_W-1:0] s1_rem_r;
  logic [CB-1:0]    s1_sat_r, s1_val_r;
  logic             s1_grey_r;

  always_comb begin
    s1_hue_c = (in_hue >= HUE_LIM) ? HUE_LIM - HUE_W'(1) : in_hue;
    s1_deg   = s1_hue_c[HUE_W-1:HF];
    if (s1_deg < 9'd60) begin
      s1_sec_nxt = SECT_RED_YEL;
    end else if (s1_deg < 9'd120) begin
      s1_sec_nxt = SECT_YEL_GRN;
    end else if (s1_deg < 9'd180) begin
      s1_sec_nxt = SECT_GRN_CYN;
    end else if (s1_deg < 9'd240) begin
      s1_sec_nxt = SECT_CYN_BLU;
    end else if (s1_deg < 9'd300) begin
      s1_sec_nxt = SECT_BLU_MAG;
    end else begin
      s1_sec_nxt = SECT_MAG_RED;
    end
    case (s1_sec_nxt)
      SECT_RED_YEL: s1_base = '0;
      SECT_YEL_GRN: s1_base = HUE_W'(64'd60 << HF);
      SECT_GRN_CYN: s1_base = HUE_W'(64'd120 << HF);
      SECT_CYN_BLU: s1_base = HUE_W'(64'd180 << HF);
      SECT_BLU_MAG: s1_base = HUE_W'(64'd240 << HF);
      default:      s1_base = HUE_W'(64'd300 << HF);
    endcase
    s1_rem_nxt = REM_W'(s1_hue_c - s1_base);
  end

  // stage 2: rem * MAXV / 2^(HF+2), and v * (1 - s)
  logic [REM_W+CB-1:0] s2_wide;
  logic [Y_W-1:0]      s2_y_nxt;
  logic [CB-1:0]       s2_sinv;
  logic [2*CB-1:0]     s2_pprod_nxt;
  sector_t             s2_sec_r;
  logic [Y_W-1:0]      s2_y_r;
  logic [2*CB-1:0]     s2_pprod_r;
  logic [CB-1:0]       s2_sat_r, s2_val_r;
  logic                s2_grey_r;

  assign s2_wide      = {s1_rem_r, {CB{1'b0}}} - {{CB{1'b0}}, s1_rem_r};
  assign s2_y_nxt     = s2_wide[REM_W+CB-1:HF+2];
  assign s2_sinv      = MAXV - s1_sat_r;
  assign s2_pprod_nxt = s1_val_r * s2_sinv;

  // stage 3: reciprocal estimate of y / 15, and p
  logic [2*CB+4:0] s3_yrec;
  logic [CB-1:0]   s3_qe_nxt;
  logic [CB-1:0]   s3_p_nxt;
  sector_t         s3_sec_r;
  logic [Y_W-1:0]  s3_y_r;
  logic [CB-1:0]   s3_qe_r, s3_p_r;
  logic [CB-1:0]   s3_sat_r, s3_val_r;
  logic            s3_grey_r;

  assign s3_yrec   = s2_y_r * RECIP;
  assign s3_qe_nxt = s3_yrec[2*CB+3:Y_W];
  assign s3_p_nxt  = div_maxv(s2_pprod_r);

  // stage 4: correct the estimate, which is low by at most one
  logic [Y_W-1:0] s4_rmd;
  logic [CB-1:0]  s4_f_nxt;
  sector_t        s4_sec_r;
  logic [CB-1:0]  s4_f_r, s4_p_r;
  logic [CB-1:0]  s4_sat_r, s4_val_r;
  logic           s4_grey_r;

  assign s4_rmd   = s3_y_r - {s3_qe_r, 4'b0} + {4'b0, s3_qe_r};
  assign s4_f_nxt = s3_qe_r + CB'(s4_rmd >= Y_W'(RECIP_DIV));

  // stage 5: s * f and s * (1 - f)
  logic [CB-1:0]   s5_finv;
  logic [2*CB-1:0] s5_sf_nxt, s5_sfi_nxt;
  sector_t         s5_sec_r;
  logic [2*CB-1:0] s5_sf_r, s5_sfi_r;
  logic [CB-1:0]   s5_p_r, s5_val_r;
  logic            s5_grey_r;

  assign s5_finv    = MAXV - s4_f_r;
  assign s5_sf_nxt  = s4_sat_r * s4_f_r;
  assign s5_sfi_nxt = s4_sat_r * s5_finv;

  // stage 6: 1 - s*f and 1 - s*(1-f)
  logic [CB-1:0] s6_a_nxt, s6_b_nxt;
  sector_t       s6_sec_r;
  logic [CB-1:0] s6_a_r, s6_b_r, s6_p_r, s6_val_r;
  logic          s6_grey_r;

  assign s6_a_nxt = MAXV - div_maxv(s5_sf_r);
  assign s6_b_nxt = MAXV - div_maxv(s5_sfi_r);

  // stage 7: v times each
  logic [2*CB-1:0] s7_qprod_nxt, s7_tprod_nxt;
  sector_t         s7_sec_r;
  logic [2*CB-1:0] s7_qprod_r, s7_tprod_r;
  logic [CB-1:0]   s7_p_r, s7_val_r;
  logic            s7_grey_r;

  assign s7_qprod_nxt = s6_val_r * s6_a_r;
  assign s7_tprod_nxt = s6_val_r * s6_b_r;

  // stage 8: q and t, pick channels by sector
  logic [CB-1:0] s8_q, s8_t;
  logic [CB-1:0] out_red_nxt, out_green_nxt, out_blue_nxt;
  logic [CB-1:0] out_red_r, out_green_r, out_blue_r;

  always_comb begin
    s8_q = div_maxv(s7_qprod_r);
    s8_t = div_maxv(s7_tprod_r);
    case (s7_sec_r)
      SECT_RED_YEL: begin
        out_red_nxt = s7_val_r; out_green_nxt = s8_t;     out_blue_nxt = s7_p_r;
      end
      SECT_YEL_GRN: begin
        out_red_nxt = s8_q;     out_green_nxt = s7_val_r; out_blue_nxt = s7_p_r;
      end
      SECT_GRN_CYN: begin
        out_red_nxt = s7_p_r;   out_green_nxt = s7_val_r; out_blue_nxt = s8_t;
      end
      SECT_CYN_BLU: begin
        out_red_nxt = s7_p_r;   out_green_nxt = s8_q;     out_blue_nxt = s7_val_r;
      end
      SECT_BLU_MAG: begin
        out_red_nxt = s8_t;     out_green_nxt = s7_p_r;   out_blue_nxt = s7_val_r;
      end
      default: begin
        out_red_nxt = s7_val_r; out_green_nxt = s7_p_r;   out_blue_nxt = s8_q;
      end
    endcase
    if (s7_grey_r) begin
      out_red_nxt   = s7_val_r;
      out_green_nxt = s7_val_r;
      out_blue_nxt  = s7_val_r;
    end
  end

  // advance each stage when it is empty or the next one moves
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sec_r  <= s1_sec_nxt;
      s1_rem_r  <= s1_rem_nxt;
      s1_sat_r  <= in_saturation;
      s1_val_r  <= in_brightness;
      s1_grey_r <= (in_saturation <= GREY_LIM);
    end
    if (en[1]) begin
      s2_sec_r   <= s1_sec_r;
      s2_y_r     <= s2_y_nxt;
      s2_pprod_r <= s2_pprod_nxt;
      s2_sat_r   <= s1_sat_r;
      s2_val_r   <= s1_val_r;
      s2_grey_r  <= s1_grey_r;
    end
    if (en[2]) begin
      s3_sec_r  <= s2_sec_r;
      s3_y_r    <= s2_y_r;
      s3_qe_r   <= s3_qe_nxt;
      s3_p_r    <= s3_p_nxt;
      s3_sat_r  <= s2_sat_r;
      s3_val_r  <= s2_val_r;
      s3_grey_r <= s2_grey_r;
    end
    if (en[3]) begin
      s4_sec_r  <= s3_sec_r;
      s4_f_r    <= s4_f_nxt;
      s4_p_r    <= s3_p_r;
      s4_sat_r  <= s3_sat_r;
      s4_val_r  <= s3_val_r;
      s4_grey_r <= s3_grey_r;
    end
    if (en[4]) begin
      s5_sec_r  <= s4_sec_r;
      s5_sf_r   <= s5_sf_nxt;
      s5_sfi_r  <= s5_sfi_nxt;
      s5_p_r    <= s4_p_r;
      s5_val_r  <= s4_val_r;
      s5_grey_r <= s4_grey_r;
    end
    if (en[5]) begin
      s6_sec_r  <= s5_sec_r;
      s6_a_r    <= s6_a_nxt;
      s6_b_r    <= s6_b_nxt;
      s6_p_r    <= s5_p_r;
      s6_val_r  <= s5_val_r;
      s6_grey_r <= s5_grey_r;
    end
    if (en[6]) begin
      s7_sec_r   <= s6_sec_r;
      s7_qprod_r <= s7_qprod_nxt;
      s7_tprod_r <= s7_tprod_nxt;
      s7_p_r     <= s6_p_r;
      s7_val_r   <= s6_val_r;
      s7_grey_r  <= s6_grey_r;
    end
    if (en[7]) begin
      out_red_r   <= out_red_nxt;
      out_green_r <= out_green_nxt;
      out_blue_r  <= out_blue_nxt;
    end
  end

  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // ---------------------------------------------------------------- checks
  a_accept_enters_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted word did not enter the first stage");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> HUE_W'(s1_rem_r) < SPAN)
    else $error("hue remainder outside its sector");

  a_recip_error: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> s4_rmd < Y_W'(2 * RECIP_DIV))
    else $error("fraction estimate off by more than one");

  a_frac_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> s4_f_r != MAXV)
    else $error("hue fraction reached full scale");

endmodule

>>> tb/sv/tb_hsv_to_rgb_converter_core.sv
`timescale 1ns / 1ps
// Self-checking bench for hsv_to_rgb_converter_core: corner and random HSV words,
// each RGB word predicted here and compared in order. Depends on hsv2rgb_pkg.

class rgb_scoreboard;
  localparam longint unsigned FULL       = 65535;
  localparam longint unsigned SPAN       = 60 * 256;
  localparam longint unsigned HUE_LIMIT  = 360 * 256;
  localparam longint unsigned GREY_LIMIT = FULL / 10000;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  rgb_t        expected_rgb_q[$];
  int unsigned checked;
  int unsigned mismatches;
  int unsigned grey_words;
  int unsigned clamped_words;

  function longint unsigned scale(longint unsigned a, longint unsigned b);
    return (a * b) / FULL;
  endfunction

  function rgb_t hsv_to_rgb(logic [16:0] hue, logic [15:0] sat, logic [15:0] val);
    longint unsigned h, s, v, rem, f, p, q, t;
    hsv2rgb_pkg::sector_t sect;
    rgb_t px;
    h = hue;
    s = sat;
    v = val;
    if (s <= GREY_LIMIT) begin
      px = '{red: val, green: val, blue: val};
      return px;
    end
    if (h >= HUE_LIMIT) h = HUE_LIMIT - 1;
    sect = hsv2rgb_pkg::sector_t'(h / SPAN);
    rem  = h - (h / SPAN) * SPAN;
    f    = (rem * FULL) / SPAN;
    p    = scale(v, FULL - s);
    q    = scale(v, FULL - scale(s, f));
    t    = scale(v, FULL - scale(s, FULL - f));
    case (sect)
      hsv2rgb_pkg::SECT_RED_YEL: px = '{red: v[15:0], green: t[15:0], blue: p[15:0]};
      hsv2rgb_pkg::SECT_YEL_GRN: px = '{red: q[15:0], green: v[15:0], blue: p[15:0]};
      hsv2rgb_pkg::SECT_GRN_CYN: px = '{red: p[15:0], green: v[15:0], blue: t[15:0]};
      hsv2rgb_pkg::SECT_CYN_BLU: px = '{red: p[15:0], green: q[15:0], blue: v[15:0]};
      hsv2rgb_pkg::SECT_BLU_MAG: px = '{red: t[15:0], green: p[15:0], blue: v[15:0]};
      default:                   px = '{red: v[15:0], green: p[15:0], blue: q[15:0]};
    endcase
    return px;
  endfunction

  function void note_pixel(logic [16:0] hue, logic [15:0] sat, logic [15:0] val);
    expected_rgb_q.push_back(hsv_to_rgb(hue, sat, val));
    if (sat <= GREY_LIMIT) grey_words++;
    else if (hue >= HUE_LIMIT) clamped_words++;
  endfunction

  function void check_pixel(logic [15:0] red, logic [15:0] green, logic [15:0] blue);
    rgb_t want;
    if (expected_rgb_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected output word r=%0d g=%0d b=%0d", red, green, blue);
      return;
    end
    want = expected_rgb_q.pop_front();
    checked++;
    if (want.red !== red || want.green !== green || want.blue !== blue) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: word %0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                 checked, want.red, want.green, want.blue, red, green, blue);
    end
  endfunction
endclass

module tb_hsv_to_rgb_converter_core;
  localparam int unsigned N_RANDOM    = 1430;
  localparam int unsigned HOLD_CYCLES = 80;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [16:0] in_hue        = '0;
  logic [15:0] in_saturation = '0;
  logic [15:0] in_brightness = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [15:0] out_red;
  logic [15:0] out_green;
  logic [15:0] out_blue;

  rgb_scoreboard sb;
  bit            sender_quiet  = 1'b0;
  int unsigned   results_seen  = 0;
  int unsigned   input_stalls  = 0;

  hsv_to_rgb_converter_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_pixel(logic [16:0] hue, logic [15:0] sat, logic [15:0] val);
    while (!sender_quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= val;
    @(posedge clk);
    while (in_stall) begin
      input_stalls++;
      @(posedge clk);
    end
    sb.note_pixel(hue, sat, val);
  endtask

  function automatic logic [16:0] pick_hue();
    int unsigned base;
    case ($urandom_range(9))
      0: return 17'($urandom_range(131071, 92160));
      1, 2: begin
        // straddle a sector boundary, the last one runs into the clamp
        base = $urandom_range(6, 1) * 15360;
        return 17'(base - 2 + $urandom_range(3));
      end
      default: return 17'($urandom_range(92159));
    endcase
  endfunction

  function automatic logic [15:0] pick_sat();
    case ($urandom_range(7))
      0:       return 16'($urandom_range(8));
      1:       return 16'(65535 - $urandom_range(1));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_val();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Output side: check accepted words, randomize stall, hold off now and then.
  initial begin : drain
    int unsigned hold_left;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        sb.check_pixel(out_red, out_green, out_blue);
        results_seen++;
        if (results_seen == 400 || results_seen == 1000) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (results_seen >= 1100 && results_seen < 1350) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 23);
      end
    end
  end

  initial begin : stimulus
    int unsigned k;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sector starts and ends plus a mid-sector hue, mostly at full scale
    send_pixel(17'd0,      16'hFFFF, 16'hFFFF);
    send_pixel(17'd15359,  16'hFFFF, 16'hFFFF);
    send_pixel(17'd15360,  16'd40000, 16'd50000);
    send_pixel(17'd30719,  16'hFFFF, 16'd12345);
    send_pixel(17'd30720,  16'd30000, 16'hFFFF);
    send_pixel(17'd38400,  16'hFFFF, 16'hFFFF);
    send_pixel(17'd46080,  16'hFFFF, 16'hFFFF);
    send_pixel(17'd61439,  16'd20000, 16'd40000);
    send_pixel(17'd61440,  16'hFFFF, 16'd0);
    send_pixel(17'd76800,  16'hFFFF, 16'hFFFF);
    send_pixel(17'd92159,  16'hFFFF, 16'hFFFF);
    // hue past 360 degrees clamps into the last sector
    send_pixel(17'd92160,  16'd50000, 16'd60000);
    send_pixel(17'd131071, 16'hFFFF, 16'hFFFF);
    // grey threshold and just above it, then other corner words
    send_pixel(17'd12345,  16'd0,    16'd40000);
    send_pixel(17'd131071, 16'd6,    16'hFFFF);
    send_pixel(17'd20000,  16'd7,    16'hFFFF);
    send_pixel(17'd7680,   16'hFFFF, 16'd1);
    send_pixel(17'd50000,  16'hFFFE, 16'hFFFF);
    send_pixel(17'd85000,  16'd32768, 16'd0);
    send_pixel(17'd0,      16'd0,    16'd0);

    for (k = 0; k < N_RANDOM; k++) begin
      // no input gaps for words 250 to 699, so the first hold-off fills the pipeline
      sender_quiet = (k >= 250 && k < 700);
      send_pixel(pick_hue(), pick_sat(), pick_val());
    end
    in_valid <= 1'b0;

    while (sb.expected_rgb_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d RGB words: %0d grey, %0d with hue clamped past 360 degrees.",
             sb.checked, sb.grey_words, sb.clamped_words);
    $display("Input held off on %0d cycles by a full pipeline; %0d mismatches.",
             input_stalls, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_rgb_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
